// ===== hdl/ucal_pkg.sv =====
// Shared constants and the cumulative month table for the seconds-to-calendar pipeline.
package ucal_pkg;

  localparam int unsigned ZONE_W   = 17;
  localparam int unsigned SECS_W   = 32;
  localparam int unsigned DAYS_W   = 16;
  localparam int unsigned DOY_W    = 9;

  localparam logic [ZONE_W-1:0] ZONE_RESET = 17'd28800;
  localparam logic [SECS_W-1:0] EPOCH_2000 = 32'd946684800;

  // Reciprocals for exact division by constants over the value ranges used
  localparam logic [25:0] RECIP_675  = 26'd50903317;  // (x >> 7) / 675, shift 35
  localparam logic [16:0] RECIP_1461 = 17'd91868;     // days / 1461, shift 27
  localparam logic [13:0] RECIP_225  = 14'd9321;      // (s >> 4) / 225, shift 21
  localparam logic [10:0] RECIP_15   = 11'd1093;      // (r >> 2) / 15, shift 14

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;

  // First day of the second, third and fourth year of a four-year cycle
  localparam logic [10:0] YEAR1_START = 11'd366;
  localparam logic [10:0] YEAR2_START = 11'd731;
  localparam logic [10:0] YEAR3_START = 11'd1096;

  // Day of year at which month idx starts; idx 13 gives the year length
  function automatic logic [DOY_W-1:0] month_start(input logic leap, input logic [3:0] idx);
    logic [DOY_W-1:0] base;
    logic [DOY_W-1:0] extra;
    unique case (idx)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      4'd13:   base = 9'd365;
      default: base = 9'd0;
    endcase
    extra = (leap && idx >= 4'd3) ? 9'd1 : 9'd0;
    return base + extra;
  endfunction

endpackage

// ===== hdl/ucal_date.sv =====
// Day count since 2000-01-01 to year offset, month and day, over four register stages.
module ucal_date (
  input  logic                       clk,
  input  logic [ucal_pkg::DAYS_W-1:0] day_count,
  output logic [7:0]                 year_offset,
  output logic [3:0]                 month_number,
  output logic [4:0]                 day_of_month
);
  import ucal_pkg::*;

  // stage a: cycle number
  logic [32:0]       cycle_prod;
  logic [5:0]        cycle_a;
  logic [DAYS_W-1:0] days_a;

  // stage b: day within cycle
  logic [16:0]       cycle_days;
  logic [DAYS_W-1:0] cycle_rem;
  logic [5:0]        cycle_b;
  logic [10:0]       day_in_cycle_b;

  // stage c: year within cycle and day of year
  logic [1:0]        year_in_cycle_next;
  logic [10:0]       doy_wide;
  logic [1:0]        year_in_cycle_c;
  logic [5:0]        cycle_c;
  logic [DOY_W-1:0]  doy_c;

  // stage d: month lookup
  logic              leap;
  logic [3:0]        month_next;
  logic [DOY_W-1:0]  month_base;
  logic [DOY_W-1:0]  mday_wide;

  assign cycle_prod = day_count * RECIP_1461;

  always_ff @(posedge clk) begin
    cycle_a <= cycle_prod[32:27];
    days_a  <= day_count;
  end

  assign cycle_days = cycle_a * DAYS_PER_CYCLE;
  assign cycle_rem  = days_a - cycle_days[DAYS_W-1:0];

  always_ff @(posedge clk) begin
    cycle_b        <= cycle_a;
    day_in_cycle_b <= cycle_rem[10:0];
  end

  always_comb begin
    priority if (day_in_cycle_b < YEAR1_START) begin
      year_in_cycle_next = 2'd0;
      doy_wide           = day_in_cycle_b;
    end else if (day_in_cycle_b < YEAR2_START) begin
      year_in_cycle_next = 2'd1;
      doy_wide           = day_in_cycle_b - YEAR1_START;
    end else if (day_in_cycle_b < YEAR3_START) begin
      year_in_cycle_next = 2'd2;
      doy_wide           = day_in_cycle_b - YEAR2_START;
    end else begin
      year_in_cycle_next = 2'd3;
      doy_wide           = day_in_cycle_b - YEAR3_START;
    end
  end

  always_ff @(posedge clk) begin
    year_in_cycle_c <= year_in_cycle_next;
    cycle_c         <= cycle_b;
    doy_c           <= doy_wide[DOY_W-1:0];
  end

  // The first year of each cycle is the leap one
  assign leap = (year_in_cycle_c == 2'd0);

  always_comb begin
    month_next = 4'd1;
    for (int i = 1; i < 13; i++) begin
      if (doy_c >= month_start(leap, 4'(i)) && doy_c < month_start(leap, 4'(i + 1))) begin
        month_next = 4'(i);
      end
    end
  end

  assign month_base = month_start(leap, month_next);
  assign mday_wide  = doy_c - month_base + 9'd1;

  always_ff @(posedge clk) begin
    year_offset  <= {cycle_c, year_in_cycle_c};
    month_number <= month_next;
    day_of_month <= mday_wide[4:0];
  end

endmodule

// ===== hdl/unix_seconds_to_calendar.sv =====
// Pipelined conversion of a Unix seconds count to local calendar date and time.

// One timestamp can be started in every cycle and busy stays low; each result appears
// for one cycle, marked by done, in start order. The pipeline has seven register
// stages: zone offset and rebase, day split, then hour, minute and second split in
// parallel with the date path (cycle, year in cycle, month lookup). The zone offset is
// written with zone_offset_wr_en and takes effect for timestamps started afterwards;
// write it while no conversion is in flight. Years count from 2000 with every fourth
// year leap, and counts before 2000 wrap modulo 2^32.
module unix_seconds_to_calendar (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [ucal_pkg::SECS_W-1:0]     unix_seconds,
  input  logic                            zone_offset_wr_en,
  input  logic signed [ucal_pkg::ZONE_W-1:0] zone_offset_seconds,
  output logic                            done,
  output logic [7:0]                      year_offset,
  output logic [3:0]                      month_number,
  output logic [4:0]                      day_of_month,
  output logic [4:0]                      hour_of_day,
  output logic [5:0]                      minute_of_hour,
  output logic [5:0]                      second_of_minute
);
  import ucal_pkg::*;

  logic [ZONE_W-1:0] zone_offset;
  logic              accept;
  logic [6:1]        valid;

  logic [SECS_W-1:0] local_secs;
  logic [SECS_W-1:0] secs_s1;

  logic [50:0]       day_prod;
  logic [DAYS_W-1:0] days_s2;
  logic [SECS_W-1:0] secs_s2;

  logic [32:0]       day_secs;
  logic [SECS_W-1:0] sod_wide;
  logic [16:0]       sod_s3;

  logic [26:0]       hour_prod;
  logic [4:0]        hour_s4;
  logic [16:0]       sod_s4;

  logic [16:0]       hour_secs;
  logic [16:0]       rem_wide;
  logic [11:0]       rem_s5;
  logic [4:0]        hour_s5;

  logic [20:0]       min_prod;
  logic [5:0]        minute_s6;
  logic [11:0]       rem_s6;
  logic [4:0]        hour_s6;

  logic [11:0]       min_secs;
  logic [11:0]       sec_wide;

  logic [7:0]        date_year;
  logic [3:0]        date_month;
  logic [4:0]        date_mday;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= ZONE_RESET;
    end else if (zone_offset_wr_en) begin
      zone_offset <= zone_offset_seconds;
    end
  end

  // valid bits move with the data; the receiver never stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      done  <= 1'b0;
    end else begin
      valid <= {valid[5:1], accept};
      done  <= valid[6];
    end
  end

  // stage 1: local time rebased to 2000-01-01
  assign local_secs = unix_seconds + {{(SECS_W-ZONE_W){zone_offset[ZONE_W-1]}}, zone_offset}
                      - EPOCH_2000;

  always_ff @(posedge clk) begin
    secs_s1 <= local_secs;
  end

  // stage 2: whole days, as (t / 128) / 675
  assign day_prod = secs_s1[SECS_W-1:7] * RECIP_675;

  always_ff @(posedge clk) begin
    days_s2 <= day_prod[50:35];
    secs_s2 <= secs_s1;
  end

  // stage 3: second of day
  assign day_secs = days_s2 * SECS_PER_DAY;
  assign sod_wide = secs_s2 - day_secs[SECS_W-1:0];

  always_ff @(posedge clk) begin
    sod_s3 <= sod_wide[16:0];
  end

  // stage 4: hour, as (s / 16) / 225
  assign hour_prod = sod_s3[16:4] * RECIP_225;

  always_ff @(posedge clk) begin
    hour_s4 <= hour_prod[25:21];
    sod_s4  <= sod_s3;
  end

  // stage 5: second of hour
  assign hour_secs = hour_s4 * SECS_PER_HOUR;
  assign rem_wide  = sod_s4 - hour_secs;

  always_ff @(posedge clk) begin
    rem_s5  <= rem_wide[11:0];
    hour_s5 <= hour_s4;
  end

  // stage 6: minute, as (r / 4) / 15
  assign min_prod = rem_s5[11:2] * RECIP_15;

  always_ff @(posedge clk) begin
    minute_s6 <= min_prod[19:14];
    rem_s6    <= rem_s5;
    hour_s6   <= hour_s5;
  end

  // stage 7: second of minute and output register
  assign min_secs = minute_s6 * SECS_PER_MIN;
  assign sec_wide = rem_s6 - min_secs;

  ucal_date u_date (
    .clk          (clk),
    .day_count    (days_s2),
    .year_offset  (date_year),
    .month_number (date_month),
    .day_of_month (date_mday)
  );

  always_ff @(posedge clk) begin
    year_offset      <= date_year;
    month_number     <= date_month;
    day_of_month     <= date_mday;
    hour_of_day      <= hour_s6;
    minute_of_hour   <= minute_s6;
    second_of_minute <= sec_wide[5:0];
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##7 done)
    else $error("transfer did not complete after seven cycles");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (hour_of_day <= 5'd23 && minute_of_hour <= 6'd59 && second_of_minute <= 6'd59))
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (month_number >= 4'd1 && month_number <= 4'd12 && day_of_month >= 5'd1))
    else $error("date out of range");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(valid[6]))
    else $error("result without a started transfer");

endmodule
